// ----- design/psdf_pkg.sv -----
package psdf_pkg;

   // sample grouping
   localparam int SAMPLES_PER_RESULT = 10;
   localparam int SAMPLE_W           = 10;
   localparam int COUNT_W            = 4;
   localparam int SUM_W              = 12;

   // filter and map widths
   localparam int CFG_W      = 8;
   localparam int AVG_W      = 16;
   localparam int SPEED_W    = 7;
   localparam int SPEED_MAX  = 127;

   // shared multiplier operands
   localparam int MUL_A_W    = 12;
   localparam int MUL_B_W    = 16;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

   // group mean as sum times a rounded-up reciprocal
   localparam int MEAN_SHIFT = 15;
   localparam int MEAN_RECIP = (2**MEAN_SHIFT + SAMPLES_PER_RESULT - 1) / SAMPLES_PER_RESULT;

   // bit-serial divider
   localparam int DIV_NUM_W  = 15;
   localparam int DIV_DEN_W  = 8;
   localparam int DIV_STEPS  = DIV_NUM_W;
   localparam int DIV_STEP_W = $clog2(DIV_STEPS);

   // register indexes
   localparam int CSR_IDX_W     = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_Q8  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_HIGH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_HIGH = 2'd3;

   // register reset values
   localparam logic [CFG_W-1:0] ALPHA_Q8_RST  = 8'd230;
   localparam logic [CFG_W-1:0] DEAD_LOW_RST  = 8'd117;
   localparam logic [CFG_W-1:0] DEAD_HIGH_RST = 8'd137;
   localparam logic [CFG_W-1:0] FULL_HIGH_RST = 8'd240;

endpackage

// ----- design/pot_speed_direction_filter_core.sv -----
// Speed and direction filter for a center-off potentiometer. Every request
// carries one 10-bit ADC sample; each is divided by 4 and summed, and every
// tenth request yields one response: the group mean drives a Q8.8 leaky
// average (weight alpha_q8/256 on the old value), and its integer part is
// mapped to a speed magnitude 0..127 and a reverse flag around the dead band
// [dead_low, dead_high], with full forward at full_high. A request that does
// not close a group is taken without a stall, even while a response waits
// in the output register. The tenth request keeps req_stall high until its
// response is loaded into that register, which also waits while the
// previous response is still held there: one shared 12x16 multiplier forms
// the group mean by a reciprocal, updates the average and scales by 127, and
// a one-bit-per-cycle divider runs 15 steps for the speed map, skipped in
// the dead band or for a zero forward span. Configuration writes are always
// ready; the user must keep them to idle time; the block does not enforce it.
module pot_speed_direction_filter_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [psdf_pkg::SAMPLE_W-1:0]         req_adc_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [psdf_pkg::SPEED_W-1:0]          rsp_speed,
   output logic                                  rsp_reverse,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [psdf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [psdf_pkg::CFG_W-1:0]            csr_wdata
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MEAN_MUL = 3'd1;
   localparam logic [2:0] S_MUL_OLD  = 3'd2;
   localparam logic [2:0] S_MUL_NEW  = 3'd3;
   localparam logic [2:0] S_CLASS    = 3'd4;
   localparam logic [2:0] S_MAP_DIV  = 3'd5;
   localparam logic [2:0] S_FIN      = 3'd6;
   localparam logic [2:0] S_OUT      = 3'd7;

   localparam int CFG_W  = psdf_pkg::CFG_W;
   localparam int NUM_W  = psdf_pkg::DIV_NUM_W;
   localparam int DEN_W  = psdf_pkg::DIV_DEN_W;
   localparam int SUM_W  = psdf_pkg::SUM_W;
   localparam int CNT_W  = psdf_pkg::COUNT_W;
   localparam int AVG_W  = psdf_pkg::AVG_W;
   localparam int SPD_W  = psdf_pkg::SPEED_W;
   localparam int STP_W  = psdf_pkg::DIV_STEP_W;

   // configuration
   logic [CFG_W-1:0] alpha_ff, alpha_in;
   logic [CFG_W-1:0] dlow_ff, dlow_in;
   logic [CFG_W-1:0] dhigh_ff, dhigh_in;
   logic [CFG_W-1:0] fhigh_ff, fhigh_in;

   // control and state
   logic [2:0]       state_ff, state_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [AVG_W-1:0] avg_ff, avg_in;
   logic [STP_W-1:0] step_ff, step_in;
   logic             rev_low_ff, rev_low_in;
   logic             den_neg_ff, den_neg_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [NUM_W-1:0]              quo_ff, quo_in;
   logic [DEN_W-1:0]              rem_ff, rem_in;
   logic [DEN_W-1:0]              div_ff, div_in;
   logic [psdf_pkg::MUL_P_W-2:0]  acc_ff, acc_in;
   logic [SPD_W-1:0]              res_speed_ff, res_speed_in;
   logic                          res_rev_ff, res_rev_in;
   logic [SPD_W-1:0]              rsp_speed_ff, rsp_speed_in;
   logic                          rsp_rev_ff, rsp_rev_in;

   // shared multiplier
   logic [psdf_pkg::MUL_A_W-1:0]  mul_a;
   logic [psdf_pkg::MUL_B_W-1:0]  mul_b;
   logic [psdf_pkg::MUL_P_W-1:0]  mul_p;
   logic [psdf_pkg::MUL_P_W-1:0]  mac_sum;

   // divider step
   logic [DEN_W:0]   div_trial;
   logic [DEN_W+1:0] div_diff;
   logic             div_ge;
   logic             div_last;

   // classification
   logic [CFG_W-1:0] avg_int;
   logic [CFG_W-1:0] fwd_off;
   logic [CFG_W:0]   fwd_den;
   logic [CFG_W-1:0] fwd_den_abs;
   logic             below;
   logic             in_band;

   logic             req_accept;
   logic             out_free;
   logic [SUM_W-1:0] sum_next;
   logic [CNT_W-1:0] count_next;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_speed   = rsp_speed_ff;
   assign rsp_reverse = rsp_rev_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   assign sum_next   = sum_ff + SUM_W'(req_adc_sample[psdf_pkg::SAMPLE_W-1:2]);
   assign count_next = count_ff + CNT_W'(1);

   assign avg_int     = avg_ff[AVG_W-1:AVG_W-CFG_W];
   assign below       = (avg_int < dlow_ff);
   assign in_band     = !below && (avg_int <= dhigh_ff);
   assign fwd_off     = avg_int - dhigh_ff;
   assign fwd_den     = {1'b0, fhigh_ff} - {1'b0, dhigh_ff};
   assign fwd_den_abs = fwd_den[CFG_W] ? CFG_W'(-fwd_den) : fwd_den[CFG_W-1:0];

   always_comb begin
      case (state_ff)
         S_MEAN_MUL: begin
            // group sum held in quo_ff
            mul_a = psdf_pkg::MUL_A_W'(quo_ff[SUM_W-1:0]);
            mul_b = psdf_pkg::MUL_B_W'(psdf_pkg::MEAN_RECIP);
         end
         S_MUL_OLD: begin
            mul_a = psdf_pkg::MUL_A_W'(alpha_ff);
            mul_b = avg_ff;
         end
         S_MUL_NEW: begin
            // (256 - alpha) * (mean << 8)
            mul_a = psdf_pkg::MUL_A_W'(9'd256 - {1'b0, alpha_ff});
            mul_b = {quo_ff[CFG_W-1:0], 8'h00};
         end
         default: begin
            mul_a = psdf_pkg::MUL_A_W'(psdf_pkg::SPEED_MAX);
            mul_b = psdf_pkg::MUL_B_W'(below ? avg_int : fwd_off);
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   assign mac_sum = mul_p + psdf_pkg::MUL_P_W'(acc_ff);

   // restoring division, one quotient bit per cycle
   assign div_trial = {rem_ff, quo_ff[NUM_W-1]};
   assign div_diff  = {1'b0, div_trial} - {2'b00, div_ff};
   assign div_ge    = !div_diff[DEN_W+1];
   assign div_last  = (step_ff == STP_W'(psdf_pkg::DIV_STEPS - 1));

   always_comb begin
      alpha_in = alpha_ff;
      dlow_in  = dlow_ff;
      dhigh_in = dhigh_ff;
      fhigh_in = fhigh_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            psdf_pkg::CSR_ALPHA_Q8:  alpha_in = csr_wdata;
            psdf_pkg::CSR_DEAD_LOW:  dlow_in  = csr_wdata;
            psdf_pkg::CSR_DEAD_HIGH: dhigh_in = csr_wdata;
            psdf_pkg::CSR_FULL_HIGH: fhigh_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      avg_in       = avg_ff;
      step_in      = step_ff;
      rev_low_in   = rev_low_ff;
      den_neg_in   = den_neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      acc_in       = acc_ff;
      res_speed_in = res_speed_ff;
      res_rev_in   = res_rev_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_speed_in = rsp_speed_ff;
      rsp_rev_in   = rsp_rev_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (count_next == CNT_W'(psdf_pkg::SAMPLES_PER_RESULT)) begin
                  sum_in   = '0;
                  count_in = '0;
                  quo_in   = NUM_W'(sum_next);
                  state_in = S_MEAN_MUL;
               end else begin
                  sum_in   = sum_next;
                  count_in = count_next;
               end
            end
         end
         S_MEAN_MUL: begin
            quo_in   = NUM_W'(mul_p[psdf_pkg::MEAN_SHIFT +: CFG_W]);
            state_in = S_MUL_OLD;
         end
         S_MAP_DIV: begin
            rem_in  = div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
            quo_in  = {quo_ff[NUM_W-2:0], div_ge};
            step_in = step_ff + STP_W'(1);
            if (div_last) begin
               state_in = S_FIN;
            end
         end
         S_MUL_OLD: begin
            acc_in   = mul_p[psdf_pkg::MUL_P_W-2:0];
            state_in = S_MUL_NEW;
         end
         S_MUL_NEW: begin
            avg_in   = mac_sum[AVG_W+7:8];
            state_in = S_CLASS;
         end
         S_CLASS: begin
            quo_in  = mul_p[NUM_W-1:0];
            rem_in  = '0;
            step_in = '0;
            if (in_band) begin
               res_speed_in = '0;
               res_rev_in   = 1'b0;
               state_in     = S_OUT;
            end else if (below) begin
               div_in     = dlow_ff;
               rev_low_in = 1'b1;
               state_in   = S_MAP_DIV;
            end else if (fwd_den == '0) begin
               // zero forward span saturates to full forward
               res_speed_in = SPD_W'(psdf_pkg::SPEED_MAX);
               res_rev_in   = 1'b0;
               state_in     = S_OUT;
            end else begin
               div_in     = fwd_den_abs;
               rev_low_in = 1'b0;
               den_neg_in = fwd_den[CFG_W];
               state_in   = S_MAP_DIV;
            end
         end
         S_FIN: begin
            if (rev_low_ff) begin
               // quotient is below 127 on the reverse side
               res_speed_in = SPD_W'(psdf_pkg::SPEED_MAX) - quo_ff[SPD_W-1:0];
               res_rev_in   = 1'b1;
            end else begin
               res_speed_in = (|quo_ff[NUM_W-1:SPD_W]) ? SPD_W'(psdf_pkg::SPEED_MAX)
                                                        : quo_ff[SPD_W-1:0];
               res_rev_in   = den_neg_ff && (quo_ff != '0);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = res_speed_ff;
               rsp_rev_in   = res_rev_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= psdf_pkg::ALPHA_Q8_RST;
         dlow_ff      <= psdf_pkg::DEAD_LOW_RST;
         dhigh_ff     <= psdf_pkg::DEAD_HIGH_RST;
         fhigh_ff     <= psdf_pkg::FULL_HIGH_RST;
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         avg_ff       <= '0;
         step_ff      <= '0;
         rev_low_ff   <= 1'b0;
         den_neg_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alpha_ff     <= alpha_in;
         dlow_ff      <= dlow_in;
         dhigh_ff     <= dhigh_in;
         fhigh_ff     <= fhigh_in;
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         avg_ff       <= avg_in;
         step_ff      <= step_in;
         rev_low_ff   <= rev_low_in;
         den_neg_ff   <= den_neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      acc_ff       <= acc_in;
      res_speed_ff <= res_speed_in;
      res_rev_ff   <= res_rev_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_rev_ff   <= rsp_rev_in;
   end

endmodule

// ----- design/psdf_checker.sv -----
module psdf_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [psdf_pkg::SPEED_W-1:0]          rsp_speed,
   input  logic                                  rsp_reverse,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready
);

   logic [psdf_pkg::COUNT_W-1:0] seen_ff, seen_in;
   logic                         req_take;
   logic                         group_end;

   assign req_take  = req_valid && !req_stall;
   assign group_end = (seen_ff == psdf_pkg::COUNT_W'(psdf_pkg::SAMPLES_PER_RESULT - 1));
   assign seen_in   = !req_take ? seen_ff
                    : group_end ? '0 : seen_ff + psdf_pkg::COUNT_W'(1);

   // requests seen since the last group closed
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_speed) && $stable(rsp_reverse))
      else $error("response changed while stalled");

   a_busy_after_group: assert property (@(posedge clock) disable iff (reset)
      req_take && group_end |=> req_stall)
      else $error("no busy period after the closing request of a group");

   a_rsp_only_after_group: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (seen_ff == '0) && $past(req_stall))
      else $error("response appeared without a completed group");

   a_reverse_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reverse |-> (rsp_speed != '0))
      else $error("reverse flag with zero speed");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind pot_speed_direction_filter_core psdf_checker u_psdf_checker (.*);
